### src/genv_pkg.sv
// Shared types, constants and the cosine table builder for the grain envelope generator.
// Depends on nothing; every other file in src imports it.
package genv_pkg;

    localparam int CURVE_POINTS = 1024;
    localparam int IDX_W        = $clog2(CURVE_POINTS);
    localparam int QTR_SIZE     = CURVE_POINTS / 2 + 1;
    localparam int QA_W         = $clog2(QTR_SIZE);
    localparam int STEP_W       = $clog2(IDX_W + 1);
    localparam int LEN_W        = 24;
    localparam int LEVEL_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int COS_W        = 31;

    localparam logic [63:0]        Q30_ONE    = 64'h0000_0000_4000_0000;
    localparam logic [63:0]        PI_Q30     = 64'd3373259426;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'h8000;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 16'h0000;

    typedef enum logic [1:0] {
        STG_OFF     = 2'd0,
        STG_ATTACK  = 2'd1,
        STG_SUSTAIN = 2'd2,
        STG_RELEASE = 2'd3
    } stage_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_LEN  = 2'd0,
        CFG_SUSTAIN_LEN = 2'd1,
        CFG_RELEASE_LEN = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DIV,
        SEQ_LOOKUP,
        SEQ_LEVEL,
        SEQ_DONE
    } seq_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef logic [COS_W-1:0] cos_rom_t [QTR_SIZE];

    // Cosine of pi*j/N in Q30 for the first half of the table, by a Horner series.
    function automatic logic [COS_W-1:0] cos_q30(input int unsigned j);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] prod;
        logic [63:0] term;
        int          k;
        t  = (PI_Q30 * 64'(j)) / 64'(CURVE_POINTS);
        t2 = (t * t) >> 30;
        r  = Q30_ONE;
        for (k = 6; k >= 1; k--)
        begin
            prod = (t2 * r) >> 30;
            term = prod / 64'((2 * k) * (2 * k - 1));
            r    = (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
        end
        return r[COS_W-1:0];
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int j = 0; j < QTR_SIZE; j++)
        begin
            rom[j] = cos_q30(j);
        end
        return rom;
    endfunction

endpackage

### src/genv_divider.sv
// Serial restoring divider that produces the table index floor(count*N/len), one bit a cycle.
// Depends on genv_pkg; the caller guarantees count < len and len != 0 at start.
module genv_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [genv_pkg::LEN_W-1:0] count,
    input  logic [genv_pkg::LEN_W-1:0] len,
    output logic [genv_pkg::IDX_W-1:0] quotient,
    output genv_pkg::div_status_t      status
);
    import genv_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  quo_reg, quo_next;
    logic [LEN_W:0]    shifted;
    logic [LEN_W+1:0]  diff;
    logic              fits;

    // The remainder stays below len, so the doubled value fits in one extra bit.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = {1'b0, shifted} - {2'b00, len_reg};
    assign fits    = ~diff[LEN_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(IDX_W);
            rem_next  = count;
            len_next  = len;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
            quo_next  = {quo_reg[IDX_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        len_reg <= len_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### src/genv_shape_rom.sv
// Quarter-period cosine ROM with registered read, folded to the half period and combined into the envelope level.
// Depends on genv_pkg for the table size and the table builder.
module genv_shape_rom (
    input  logic                         clk,
    input  logic [genv_pkg::IDX_W-1:0]   idx,
    input  logic                         rising,
    output logic [genv_pkg::LEVEL_W-1:0] level
);
    import genv_pkg::*;

    localparam cos_rom_t         COS_ROM = build_cos_rom();
    localparam logic [IDX_W:0]   HALF    = (IDX_W + 1)'(CURVE_POINTS / 2);
    localparam logic [IDX_W:0]   FULL    = (IDX_W + 1)'(CURVE_POINTS);
    localparam logic [31:0]      ONE_32  = 32'h4000_0000;
    localparam logic [31:0]      ROUND   = 32'h0000_8000;

    logic             neg;
    logic [IDX_W:0]   mirrored;
    logic [QA_W-1:0]  addr;
    logic [COS_W-1:0] cos_reg;
    logic             sub_reg;
    logic [31:0]      sum;

    // Entries past the middle read the mirrored entry with the cosine negated.
    assign neg      = {1'b0, idx} > HALF;
    assign mirrored = neg ? (FULL - {1'b0, idx}) : {1'b0, idx};
    assign addr     = QA_W'(mirrored);

    always_ff @(posedge clk)
    begin
        cos_reg <= COS_ROM[addr];
        sub_reg <= (rising != neg);
    end

    assign sum   = sub_reg ? (ONE_32 - {1'b0, cos_reg} + ROUND)
                           : (ONE_32 + {1'b0, cos_reg} + ROUND);
    assign level = sum[31:16];

endmodule

### src/grain_envelope_generator.sv
// Top level of the grain envelope generator: sequencer, stage state, configuration and output.
// Depends on genv_pkg, genv_divider and genv_shape_rom.

// Each input transaction is one sample tick carrying a trigger request; each one produces
// exactly one output transaction with the Q1.15 level (32768 is full scale) and the
// envelope_off flag after the tick. A trigger starts a new grain only while the envelope is
// off. Ticks in the off and sustain stages skip the divider and the table lookup. Ticks in
// attack and release compute the table index floor(counter*N/length) with a shared serial
// divider that yields one quotient bit per cycle. When the length is zero or the counter
// already reaches the length, the divider is skipped. The result sits in an output
// register, so the next transaction is accepted while the previous result is still stalled
// downstream. Lengths are written through the plain configuration port and take effect on
// the next tick; the user must write them only while the block is idle, which the block
// itself does not enforce.
module grain_envelope_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           trigger_request,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [genv_pkg::LEVEL_W-1:0]   level,
    output logic                           envelope_off,
    input  logic                           cfg_write,
    input  logic [genv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [genv_pkg::LEN_W-1:0]     cfg_data
);
    import genv_pkg::*;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CURVE_POINTS - 1);

    seq_t               seq_reg, seq_next;
    stage_t             stage_reg, stage_next;
    logic [LEN_W-1:0]   counter_reg, counter_next;
    logic [LEN_W-1:0]   attack_len_reg, attack_len_next;
    logic [LEN_W-1:0]   sustain_len_reg, sustain_len_next;
    logic [LEN_W-1:0]   release_len_reg, release_len_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic               out_off_reg, out_off_next;

    logic               in_take;
    logic               out_take;
    stage_t             stage_eff;
    logic [LEN_W-1:0]   counter_eff;
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W:0]     counter_inc;
    stage_t             stage_after;
    logic               div_start;
    logic [IDX_W-1:0]   div_quotient;
    div_status_t        div_status;
    logic [LEVEL_W-1:0] rom_level;

    assign in_stall = (seq_reg != SEQ_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // A trigger only matters when the envelope is off; it restarts attack from zero.
    always_comb
    begin
        if (trigger_request && (stage_reg == STG_OFF))
        begin
            stage_eff   = STG_ATTACK;
            counter_eff = '0;
        end
        else
        begin
            stage_eff   = stage_reg;
            counter_eff = counter_reg;
        end
        case (stage_eff)
            STG_ATTACK:  len_eff = attack_len_reg;
            STG_RELEASE: len_eff = release_len_reg;
            default:     len_eff = sustain_len_reg;
        endcase
    end

    // Stage that follows the current tick, once its count reaches the stage length.
    always_comb
    begin
        counter_inc = {1'b0, counter_reg} + (LEN_W + 1)'(1);
        stage_after = stage_reg;
        if ((stage_reg != STG_OFF) && (counter_inc >= {1'b0, len_reg}))
        begin
            case (stage_reg)
                STG_ATTACK:  stage_after = STG_SUSTAIN;
                STG_SUSTAIN: stage_after = STG_RELEASE;
                default:     stage_after = STG_OFF;
            endcase
        end
    end

    always_comb
    begin
        seq_next         = seq_reg;
        stage_next       = stage_reg;
        counter_next     = counter_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        level_next       = level_reg;
        out_valid_next   = out_valid_reg && !out_take;
        out_level_next   = out_level_reg;
        out_off_next     = out_off_reg;
        div_start        = 1'b0;
        attack_len_next  = attack_len_reg;
        sustain_len_next = sustain_len_reg;
        release_len_next = release_len_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ATTACK_LEN:  attack_len_next  = cfg_data;
                CFG_SUSTAIN_LEN: sustain_len_next = cfg_data;
                CFG_RELEASE_LEN: release_len_next = cfg_data;
                default:         ;
            endcase
        end

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_take)
                begin
                    stage_next   = stage_eff;
                    counter_next = counter_eff;
                    len_next     = len_eff;
                    case (stage_eff)
                        STG_OFF:
                        begin
                            level_next = LEVEL_ZERO;
                            seq_next   = SEQ_DONE;
                        end
                        STG_SUSTAIN:
                        begin
                            level_next = LEVEL_FULL;
                            seq_next   = SEQ_DONE;
                        end
                        default:
                        begin
                            // Zero length reads the first entry; a counter at or past the
                            // length (length lowered mid-stage) reads the last one.
                            if (len_eff == '0)
                            begin
                                idx_next = '0;
                                seq_next = SEQ_LOOKUP;
                            end
                            else if (counter_eff >= len_eff)
                            begin
                                idx_next = IDX_MAX;
                                seq_next = SEQ_LOOKUP;
                            end
                            else
                            begin
                                div_start = 1'b1;
                                seq_next  = SEQ_DIV;
                            end
                        end
                    endcase
                end
            end
            SEQ_DIV:
            begin
                if (div_status.done)
                begin
                    idx_next = div_quotient;
                    seq_next = SEQ_LOOKUP;
                end
            end
            SEQ_LOOKUP:
            begin
                seq_next = SEQ_LEVEL;
            end
            SEQ_LEVEL:
            begin
                level_next = rom_level;
                seq_next   = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_off_next   = (stage_after == STG_OFF);
                    stage_next     = stage_after;
                    if (stage_reg != STG_OFF)
                    begin
                        counter_next = (stage_after != stage_reg) ? '0
                                                                  : counter_inc[LEN_W-1:0];
                    end
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SEQ_IDLE;
            stage_reg       <= STG_OFF;
            counter_reg     <= '0;
            attack_len_reg  <= LEN_W'(64);
            sustain_len_reg <= LEN_W'(256);
            release_len_reg <= LEN_W'(64);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seq_reg         <= seq_next;
            stage_reg       <= stage_next;
            counter_reg     <= counter_next;
            attack_len_reg  <= attack_len_next;
            sustain_len_reg <= sustain_len_next;
            release_len_reg <= release_len_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        level_reg     <= level_next;
        out_level_reg <= out_level_next;
        out_off_reg   <= out_off_next;
    end

    genv_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .count    (counter_eff),
        .len      (len_eff),
        .quotient (div_quotient),
        .status   (div_status)
    );

    genv_shape_rom u_shape_rom (
        .clk    (clk),
        .idx    (idx_reg),
        .rising (stage_reg == STG_ATTACK),
        .level  (rom_level)
    );

    assign out_valid    = out_valid_reg;
    assign level        = out_level_reg;
    assign envelope_off = out_off_reg;

    // An accepted transaction keeps the input side closed for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // Only the shaped stages use the table lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_LOOKUP) |-> (stage_reg == STG_ATTACK || stage_reg == STG_RELEASE))
        else $error("table lookup outside attack or release");

    // A finished level waits while the output register still holds an untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_DONE) && out_valid_reg && out_stall |=> (seq_reg == SEQ_DONE))
        else $error("result overwrote a stalled output transaction");

    // The divider is only busy while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (seq_reg == SEQ_DIV))
        else $error("divider running outside the divide state");

endmodule

### dv/tb_grain_envelope_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for grain_envelope_generator: sample ticks in, envelope levels out.
// Depends on genv_pkg and the grain_envelope_generator RTL; needs no files or arguments.
module tb_grain_envelope_generator;
    import genv_pkg::*;

    // The configuration port has one index that maps to no register; writes to it must be lost.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Fixed-point constants for the raised-cosine shape, Q30 format.
    localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;
    localparam logic [63:0] PI_IN_Q30 = 64'd3373259426;
    localparam logic [LEN_W-1:0] LEN_MAX = 24'hFF_FFFF;

    // Random part size, receiver hold-off length and the stuck-run limit of the watchdog.
    // The slowest correct transaction is its own work plus the longest sender gap and a full
    // receiver hold-off, far below the stuck-run limit, so reaching it can only mean a hang.
    localparam int RANDOM_ITEMS = 430;
    localparam int HOLD_CYCLES = 150;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic               off;
    } level_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 trigger_request;
    logic                 out_valid;
    logic                 out_stall;
    logic [LEVEL_W-1:0]   level;
    logic                 envelope_off;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    // Our own copy of the envelope state and the three length registers, at reset values.
    stage_t           env_stage = STG_OFF;
    logic [LEN_W-1:0] env_count = '0;
    logic [LEN_W-1:0] attack_len = 24'd64;
    logic [LEN_W-1:0] sustain_len = 24'd256;
    logic [LEN_W-1:0] release_len = 24'd64;

    // Levels still owed by the block, oldest first.
    level_result_t expected_levels[$];

    int  mismatch_count = 0;
    int  stuck_cycles = 0;
    int  hold_requests = 0;
    bit  idling_on = 1'b1;

    grain_envelope_generator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .trigger_request (trigger_request),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .level           (level),
        .envelope_off    (envelope_off),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------------------
    // Envelope predictor
    // ------------------------------------------------------------------------------------

    // Cosine of pi*j/N for the first half of the table, as a Horner series in Q30. Every
    // product is floored by 2^30, every division floored, and each difference stops at zero.
    function automatic logic [63:0] cos_series_q30(input logic [63:0] j);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        logic [63:0] term;
        int          k;
        t  = (PI_IN_Q30 * j) / 64'(CURVE_POINTS);
        t2 = (t * t) >> 30;
        r  = ONE_Q30;
        for (k = 6; k >= 1; k--)
        begin
            term = ((t2 * r) >> 30) / 64'((2 * k) * (2 * k - 1));
            r    = (term >= ONE_Q30) ? 64'd0 : (ONE_Q30 - term);
        end
        return r;
    endfunction

    // Level of one table entry: (1 - cos)/2 when rising, (1 + cos)/2 when falling, rounded
    // to Q1.15. Entries past the midpoint mirror the first half with the cosine negated.
    function automatic logic [LEVEL_W-1:0] curve_level(input int unsigned idx, input bit rising);
        logic [63:0] j;
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] rounded;
        bit          negated;
        j       = 64'(idx);
        negated = 1'b0;
        if (2 * j > 64'(CURVE_POINTS))
        begin
            j       = 64'(CURVE_POINTS) - j;
            negated = 1'b1;
        end
        c = cos_series_q30(j);
        if (rising != negated)
            v = ONE_Q30 - c;
        else
            v = ONE_Q30 + c;
        rounded = (v + 64'h8000) >> 16;
        return rounded[LEVEL_W-1:0];
    endfunction

    // Table position floor(count*N/len); a zero length reads entry 0, overshoot clamps.
    function automatic int unsigned curve_index(input logic [LEN_W-1:0] count,
                                                input logic [LEN_W-1:0] len);
        logic [63:0] q;
        if (len == '0)
            return 0;
        q = (64'(count) * 64'(CURVE_POINTS)) / 64'(len);
        if (q > 64'(CURVE_POINTS - 1))
            q = 64'(CURVE_POINTS - 1);
        return int'(q);
    endfunction

    // One sample tick: optional trigger, level of the current stage, then the counter step.
    task automatic step_envelope(input logic trig, output level_result_t res);
        logic [LEN_W:0]   bumped;
        logic [LEN_W-1:0] len;
        stage_t           next_stage;
        len        = '0;
        next_stage = STG_OFF;
        if (trig && env_stage == STG_OFF)
        begin
            env_stage = STG_ATTACK;
            env_count = '0;
        end
        case (env_stage)
            STG_ATTACK:
            begin
                res.level  = curve_level(curve_index(env_count, attack_len), 1'b1);
                len        = attack_len;
                next_stage = STG_SUSTAIN;
            end
            STG_SUSTAIN:
            begin
                res.level  = LEVEL_FULL;
                len        = sustain_len;
                next_stage = STG_RELEASE;
            end
            STG_RELEASE:
            begin
                res.level  = curve_level(curve_index(env_count, release_len), 1'b0);
                len        = release_len;
                next_stage = STG_OFF;
            end
            default:
            begin
                res.level = LEVEL_ZERO;
            end
        endcase
        if (env_stage != STG_OFF)
        begin
            bumped = {1'b0, env_count} + 1'b1;
            if (bumped >= {1'b0, len})
            begin
                env_stage = next_stage;
                env_count = '0;
            end
            else
            begin
                env_count = bumped[LEN_W-1:0];
            end
        end
        res.off = (env_stage == STG_OFF);
    endtask

    // ------------------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------------------

    // Offers one tick on the input channel and, once the transaction is accepted, records the
    // level it must produce. Valid is left high on return so that back-to-back ticks never
    // lower and raise it within one time step; anything else that follows drops it first.
    task automatic send_tick(input logic trig);
        level_result_t predicted;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid        <= 1'b1;
        trigger_request <= trig;
        do
            @(posedge clk);
        while (in_stall);
        step_envelope(trig, predicted);
        expected_levels.push_back(predicted);
    endtask

    // Drops valid and waits until every owed level has come back, leaving the block idle.
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
    endtask

    // Writes one length register; only called while the block is idle.
    task automatic write_length(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_ATTACK_LEN:  attack_len = value;
            CFG_SUSTAIN_LEN: sustain_len = value;
            CFG_RELEASE_LEN: release_len = value;
            default:         ;
        endcase
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 24'd1;
            2:       return LEN_MAX;
            3, 4, 5: return 24'($urandom_range(2, 24));
            default: return 24'($urandom_range(25, 160));
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Result side: random stalls, requested hold-offs, and the check of every transaction
    // ------------------------------------------------------------------------------------

    // The receiver stalls about one cycle in five while idling is on. A hold-off request from
    // a test makes it refuse results for a long stretch, counted here, so that the output
    // register fills and the block has to stall its input.
    initial
    begin : result_sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (idling_on)
                out_stall <= ($urandom_range(0, 99) < 20);
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : level_checker
        level_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("unexpected result transaction: level %0d, envelope_off %0b",
                       level, envelope_off);
                mismatch_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, level);
                    mismatch_count++;
                end
                if (envelope_off !== want.off)
                begin
                    $error("envelope_off: expected %0b, got %0b", want.off, envelope_off);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither channel completes a transaction for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[grain_envelope_generator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // A full grain at the reset lengths (64, 256, 64), with trigger noise while it runs.
    // Ticks before the trigger must read zero with the envelope off.
    task automatic test_reset_lengths();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        while (env_stage != STG_OFF)
            send_tick(1'($urandom_range(0, 1)));
        send_tick(1'b0);
    endtask

    // Short stages, so every stage and both halves of the cosine table show up in a few ticks.
    // Triggers arrive while the grain runs and must be ignored.
    task automatic test_short_grain();
        wait_drain();
        write_length(CFG_UNUSED, LEN_MAX);
        write_length(CFG_ATTACK_LEN, 24'd3);
        write_length(CFG_SUSTAIN_LEN, 24'd2);
        write_length(CFG_RELEASE_LEN, 24'd5);
        repeat (10) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Zero lengths last a single sample each; in attack and release they read table entry 0.
    task automatic test_zero_lengths();
        wait_drain();
        write_length(CFG_ATTACK_LEN, '0);
        write_length(CFG_SUSTAIN_LEN, '0);
        write_length(CFG_RELEASE_LEN, '0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // Maximum lengths, then lengths lowered mid-stage: the counter overshoots, the index
    // clamps to the last entry and the stage ends at once. The last step lands on the
    // midpoint entry of the release curve.
    task automatic test_max_lengths();
        wait_drain();
        write_length(CFG_ATTACK_LEN, LEN_MAX);
        write_length(CFG_SUSTAIN_LEN, LEN_MAX);
        write_length(CFG_RELEASE_LEN, LEN_MAX);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drain();
        write_length(CFG_ATTACK_LEN, 24'd1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drain();
        write_length(CFG_SUSTAIN_LEN, 24'd1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_drain();
        write_length(CFG_RELEASE_LEN, 24'd2);
        send_tick(1'b0);
    endtask

    // The receiver holds off while the sender keeps offering ticks without gaps.
    task automatic test_backpressure();
        wait_drain();
        write_length(CFG_ATTACK_LEN, 24'd7);
        write_length(CFG_SUSTAIN_LEN, 24'd3);
        write_length(CFG_RELEASE_LEN, 24'd9);
        idling_on = 1'b0;
        hold_requests++;
        send_tick(1'b1);
        repeat (20) send_tick(1'($urandom_range(0, 1)));
        idling_on = 1'b1;
    endtask

    // Random phases. Between phases the block drains and some lengths are rewritten, often
    // in mid-grain. Ticks mostly trigger while the envelope is off so that grains keep
    // running; while a grain runs the trigger is random noise. Some phases run with no
    // idling on either side.
    task automatic test_random_grains();
        int   sent;
        int   burst;
        logic trig;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drain();
            idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                write_length(CFG_ATTACK_LEN, pick_length());
            if ($urandom_range(0, 1))
                write_length(CFG_SUSTAIN_LEN, pick_length());
            if ($urandom_range(0, 1))
                write_length(CFG_RELEASE_LEN, pick_length());
            if ($urandom_range(0, 7) == 0)
                write_length(CFG_UNUSED, 24'($urandom));
            burst = idling_on ? $urandom_range(10, 50) : $urandom_range(40, 90);
            repeat (burst)
            begin
                if (env_stage == STG_OFF)
                    trig = ($urandom_range(0, 9) < 8);
                else
                    trig = 1'($urandom_range(0, 1));
                send_tick(trig);
            end
            sent += burst;
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        trigger_request = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_ATTACK_LEN;
        cfg_data        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_lengths();
        test_short_grain();
        test_zero_lengths();
        test_max_lengths();
        test_backpressure();
        test_random_grains();

        // Let any stray result show up before the verdict.
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("[grain_envelope_generator] OK");
        else
            $display("[grain_envelope_generator] ERROR");
        $finish;
    end

endmodule

### filelist.f
src/genv_pkg.sv
src/genv_divider.sv
src/genv_shape_rom.sv
src/grain_envelope_generator.sv
dv/tb_grain_envelope_generator.sv
